>>> hdl/pointwise_small_matvec_assert.svh
// assertion macros for the pointwise small matrix-vector block
`ifndef POINTWISE_SMALL_MATVEC_ASSERT_SVH
`define POINTWISE_SMALL_MATVEC_ASSERT_SVH

// implication checked at every clock edge outside reset
`define PWMV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked at every clock edge outside reset
`define PWMV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pwmv_pkg.sv
// shared types, constants and coefficient selection for the matrix-vector block
package pwmv_pkg;

    localparam int MAX_DIM   = 3;
    localparam int Q_W       = 32;
    localparam int PROD_W    = 2 * Q_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_W    = 16;
    localparam int SHIFT_W   = SUM_W - FRAC_W;
    localparam int IN_FIELDS = MAX_DIM * MAX_DIM + MAX_DIM;
    localparam int IN_W      = IN_FIELDS * Q_W;
    localparam int OUT_W     = MAX_DIM * Q_W;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 2;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_KIND     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_TRANSPOSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_IN_USE    = 2'd2;

    typedef enum logic [1:0] {
        KIND_SCALAR = 2'd0,
        KIND_DIAG   = 2'd1,
        KIND_FULL   = 2'd2
    } kind_t;

    typedef logic signed [Q_W-1:0] q16_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef q16_t q16_vec_t [MAX_DIM];
    typedef q16_vec_t q16_mat_t [MAX_DIM];

    typedef struct packed {
        logic en_prod;
        logic en_sum;
    } pwmv_ctrl_t;

    function automatic q16_t coef_sel(
        input kind_t              kind,
        input logic               transpose,
        input logic [DIM_W-1:0]   dim,
        input q16_mat_t           a,
        input logic [IDX_W-1:0]   r,
        input logic [IDX_W-1:0]   c
    );
        q16_t coef;
        coef = '0;
        if ((DIM_W'(c) < dim) && (DIM_W'(r) < dim))
        begin
            case (kind)
                KIND_SCALAR:
                begin
                    if (c == r)
                        coef = a[0][0];
                end
                KIND_DIAG:
                begin
                    if (c == r)
                        coef = a[r][r];
                end
                default:
                begin
                    coef = transpose ? a[c][r] : a[r][c];
                end
            endcase
        end
        return coef;
    endfunction

endpackage

>>> hdl/pointwise_small_matvec.sv
// top level of the pointwise small matrix-vector product
// Takes one request per clock unless back-pressure on m_tready stalls the pipeline, and
// returns its product vector through the product, row sum with clamp and output
// registers: three row lanes each hold three 32x32 multipliers, so a full 3x3
// product is done in a single pass. The left operand kind, transpose and dimension
// come from the configuration port and apply to every request; rows and columns
// at or beyond the dimension contribute zero.
module pointwise_small_matvec (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pwmv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pwmv_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // mat_a00, a01, a02, a10, a11, a12, a20, a21, a22, vec_x0, vec_x1, vec_x2
    input  logic [pwmv_pkg::IN_W-1:0]            s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pwmv_pkg::OUT_W-1:0]           m_tdata,   // res_y0, res_y1, res_y2
    output logic                                 m_tuser    // saturated
);
    import pwmv_pkg::*;

    `include "pointwise_small_matvec_assert.svh"

    kind_t            kind_reg;
    logic             transpose_reg;
    logic [DIM_W-1:0] dim_reg;
    logic             v1_reg;
    logic             v1_next;
    logic             v2_reg;
    logic             v2_next;
    logic             en_out;
    pwmv_ctrl_t       ctrl;
    q16_mat_t         mat_w;
    q16_vec_t         x_w;
    q16_vec_t         coef_w [MAX_DIM];
    q16_vec_t         lane_y;
    logic [MAX_DIM-1:0] lane_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_FULL;
            transpose_reg <= 1'b0;
            dim_reg       <= DIM_W'(MAX_DIM);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEFT_KIND:     kind_reg      <= kind_t'(cfg_data);
                REG_USE_TRANSPOSE: transpose_reg <= cfg_data[0];
                REG_DIM_IN_USE:    dim_reg       <= cfg_data[DIM_W-1:0];
                default:           ;
            endcase
        end
    end

    // pipeline advance: a stage moves when it is empty or the next one moves
    assign ctrl.en_sum  = !v2_reg || en_out;
    assign ctrl.en_prod = !v1_reg || ctrl.en_sum;
    assign s_tready     = ctrl.en_prod;

    always_comb
    begin
        v1_next = ctrl.en_prod ? s_tvalid : v1_reg;
        v2_next = ctrl.en_sum ? v1_reg : v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_comb
    begin
        for (int r = 0; r < MAX_DIM; r++)
        begin
            for (int c = 0; c < MAX_DIM; c++)
            begin
                mat_w[r][c] = s_tdata[(r*MAX_DIM + c)*Q_W +: Q_W];
            end
            x_w[r] = s_tdata[(MAX_DIM*MAX_DIM + r)*Q_W +: Q_W];
        end
        for (int r = 0; r < MAX_DIM; r++)
        begin
            for (int c = 0; c < MAX_DIM; c++)
            begin
                coef_w[r][c] = coef_sel(kind_reg, transpose_reg, dim_reg, mat_w,
                                        IDX_W'(r), IDX_W'(c));
            end
        end
    end

    for (genvar r = 0; r < MAX_DIM; r++)
    begin : g_lane
        pwmv_lane u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .coef (coef_w[r]),
            .x    (x_w),
            .y    (lane_y[r]),
            .sat  (lane_sat[r])
        );
    end

    pwmv_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v2_reg),
        .lane_y   (lane_y),
        .lane_sat (lane_sat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .load     (en_out)
    );

    `PWMV_ASSERT_IMP(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready && v1_reg && v2_reg, "input stalled while pipeline has room")
    `PWMV_ASSERT_IMP(a_sat_means_clamped, m_tvalid && m_tuser, m_tdata[Q_W-1:0] == Q_MAX || m_tdata[Q_W-1:0] == Q_MIN || m_tdata[2*Q_W-1:Q_W] == Q_MAX || m_tdata[2*Q_W-1:Q_W] == Q_MIN || m_tdata[3*Q_W-1:2*Q_W] == Q_MAX || m_tdata[3*Q_W-1:2*Q_W] == Q_MIN, "saturated flag without a clamped component")
    `PWMV_ASSERT_NEXT(a_out_from_sum_stage, !m_tvalid && !v2_reg, !m_tvalid, "result request without a finished sum")

endmodule

>>> hdl/pwmv_lane.sv
// one row lane: three registered products, then sum, floor to q16.16 and clamp
module pwmv_lane (
    input  logic                 clk,
    input  pwmv_pkg::pwmv_ctrl_t ctrl,
    input  pwmv_pkg::q16_vec_t   coef,
    input  pwmv_pkg::q16_vec_t   x,
    output pwmv_pkg::q16_t       y,
    output logic                 sat
);
    import pwmv_pkg::*;

    prod_t                     prod_reg [MAX_DIM];
    prod_t                     prod_next [MAX_DIM];
    logic signed [SUM_W-1:0]   sum_w;
    logic signed [SHIFT_W-1:0] shift_w;
    logic                      fits_w;
    q16_t                      y_reg;
    q16_t                      y_next;
    logic                      sat_reg;
    logic                      sat_next;

    always_comb
    begin
        for (int c = 0; c < MAX_DIM; c++)
        begin
            prod_next[c] = PROD_W'(coef[c]) * PROD_W'(x[c]);
        end
    end

    always_comb
    begin
        sum_w = '0;
        for (int c = 0; c < MAX_DIM; c++)
        begin
            sum_w = sum_w + SUM_W'(prod_reg[c]);
        end
        shift_w = sum_w[SUM_W-1:FRAC_W];
        fits_w  = (&shift_w[SHIFT_W-1:Q_W-1]) | ~(|shift_w[SHIFT_W-1:Q_W-1]);
        if (fits_w)
        begin
            y_next   = shift_w[Q_W-1:0];
            sat_next = 1'b0;
        end
        else
        begin
            y_next   = shift_w[SHIFT_W-1] ? Q_MIN : Q_MAX;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_prod)
        begin
            for (int c = 0; c < MAX_DIM; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
        if (ctrl.en_sum)
        begin
            y_reg   <= y_next;
            sat_reg <= sat_next;
        end
    end

    assign y   = y_reg;
    assign sat = sat_reg;

endmodule

>>> hdl/pwmv_merge.sv
// output stage: packs the lane results, merges clamp flags, holds the request
module pwmv_merge (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  pwmv_pkg::q16_vec_t       lane_y,
    input  logic [pwmv_pkg::MAX_DIM-1:0] lane_sat,
    input  logic                     m_tready,
    output logic                     m_tvalid,
    output logic [pwmv_pkg::OUT_W-1:0] m_tdata,   // res_y0, res_y1, res_y2
    output logic                     m_tuser,   // saturated
    output logic                     load
);
    import pwmv_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [OUT_W-1:0] data_reg;
    logic [OUT_W-1:0] data_next;
    logic             sat_reg;
    logic             sat_next;

    assign load = !valid_reg || m_tready;

    always_comb
    begin
        for (int r = 0; r < MAX_DIM; r++)
        begin
            data_next[r*Q_W +: Q_W] = lane_y[r];
        end
        sat_next   = |lane_sat;
        valid_next = load ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = sat_reg;

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the pointwise small matrix-vector product block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pwmv_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam logic [1:0]           KIND_UNUSED = 2'd3;
    localparam logic [Q_W-1:0]       ONE_Q       = 32'h0001_0000;
    localparam int                   RAND_ITEMS  = 2000;

    typedef logic [IN_FIELDS-1:0][Q_W-1:0] point_t;

    typedef struct packed {
        logic [MAX_DIM-1:0][Q_W-1:0] y;
        logic                        sat;
    } product_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic             trn;
        logic [DIM_W-1:0] dim;
        logic             junk_wr;
        point_t           pt;
        logic             typed;
        product_t         prod;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tuser;

    product_t         product_q[$];
    dir_row_t         dir_tab[$];
    int               err_cnt;
    int               tx_idle_pct;
    int               rx_idle_pct;
    logic [1:0]       sh_kind;
    logic             sh_trn;
    logic [DIM_W-1:0] sh_dim;

    pointwise_small_matvec dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic product_t calc_product(input point_t pt);
        product_t                 res;
        logic signed [PROD_W+3:0] acc;
        logic signed [PROD_W+3:0] sh;
        q16_t                     coef;
        q16_t                     xv;
        int                       r;
        int                       c;
        res = '0;
        for (r = 0; r < MAX_DIM; r++)
        begin
            if (r < sh_dim)
            begin
                acc = '0;
                for (c = 0; c < sh_dim; c++)
                begin
                    coef = '0;
                    if (sh_kind == KIND_SCALAR)
                    begin
                        if (c == r)
                            coef = pt[0];
                    end
                    else if (sh_kind == KIND_DIAG)
                    begin
                        if (c == r)
                            coef = pt[r * MAX_DIM + r];
                    end
                    else
                        coef = sh_trn ? pt[c * MAX_DIM + r] : pt[r * MAX_DIM + c];
                    xv  = pt[MAX_DIM * MAX_DIM + c];
                    acc = acc + coef * xv;
                end
                sh = acc >>> FRAC_W;
                if (sh > Q_MAX)
                begin
                    res.y[r] = Q_MAX;
                    res.sat  = 1'b1;
                end
                else if (sh < Q_MIN)
                begin
                    res.y[r] = Q_MIN;
                    res.sat  = 1'b1;
                end
                else
                    res.y[r] = sh[Q_W-1:0];
            end
        end
        return res;
    endfunction

    function automatic logic [Q_W-1:0] rand_q();
        logic [Q_W-1:0] v;
        v = $urandom_range(0, 32'h0008_0000);
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3: return v;
            4, 5: return -v;
            default: return $urandom();
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t pt;
        int     i;
        for (i = 0; i < IN_FIELDS; i++)
            pt[i] = rand_q();
        return pt;
    endfunction

    function automatic dir_row_t mk_row(
        input logic [1:0]                  kind,
        input logic                        trn,
        input logic [DIM_W-1:0]            dim,
        input logic                        junk_wr,
        input point_t                      pt,
        input logic                        typed,
        input logic [MAX_DIM-1:0][Q_W-1:0] y,
        input logic                        sat
    );
        dir_row_t row;
        row.kind     = kind;
        row.trn      = trn;
        row.dim      = dim;
        row.junk_wr  = junk_wr;
        row.pt       = pt;
        row.typed    = typed;
        row.prod.y   = y;
        row.prod.sat = sat;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [Q_W-1:0] want,
                                   input logic [Q_W-1:0] got);
        $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
        err_cnt++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_LEFT_KIND:     sh_kind = val;
            REG_USE_TRANSPOSE: sh_trn  = val[0];
            REG_DIM_IN_USE:    sh_dim  = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (product_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] kind, input logic trn,
                              input logic [DIM_W-1:0] dim, input logic junk_wr);
        drain();
        write_reg(REG_LEFT_KIND, kind);
        write_reg(REG_USE_TRANSPOSE, {1'b0, trn});
        write_reg(REG_DIM_IN_USE, dim);
        if (junk_wr)
            write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 3)));
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input point_t pt, input logic typed, input product_t prod);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pt;
        do
            @(posedge clk);
        while (!s_tready);
        product_q.push_back(typed ? prod : calc_product(pt));
    endtask

    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
    begin : result_check
        product_t want;
        int       r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (product_q.size() == 0)
                report_mismatch("result with no request pending", '0, m_tdata[Q_W-1:0]);
            else
            begin
                want = product_q.pop_front();
                for (r = 0; r < MAX_DIM; r++)
                    if (m_tdata[r*Q_W +: Q_W] !== want.y[r])
                        report_mismatch($sformatf("res_y%0d", r), want.y[r],
                                        m_tdata[r*Q_W +: Q_W]);
                if (m_tuser !== want.sat)
                    report_mismatch("saturated", Q_W'(want.sat), Q_W'(m_tuser));
            end
        end
    end

    initial
    begin : stimulus
        int ph;
        int sent;
        int n_blk;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        sh_kind     = KIND_FULL;
        sh_trn      = 1'b0;
        sh_dim      = DIM_W'(MAX_DIM);
        err_cnt     = 0;
        tx_idle_pct = 10;
        rx_idle_pct = 87;

        // after reset: full matrix, plain, dimension three
        dir_tab.push_back(mk_row(KIND_FULL, 1'b0, 2'd3, 1'b0, '0, 1'b1, '0, 1'b0));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b0, 2'd3, 1'b0,
            {32'h0000_8000, 32'hFFFD_0000, 32'h0002_0000, ONE_Q, 32'h0, 32'h0,
             32'h0, ONE_Q, 32'h0, 32'h0, 32'h0, ONE_Q},
            1'b1, {32'h0000_8000, 32'hFFFD_0000, 32'h0002_0000}, 1'b0));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b0, 2'd3, 1'b0, {IN_FIELDS{Q_MAX}},
            1'b1, {MAX_DIM{Q_MAX}}, 1'b1));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b0, 2'd3, 1'b0, {IN_FIELDS{Q_MIN}},
            1'b1, {MAX_DIM{Q_MAX}}, 1'b1));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b0, 2'd3, 1'b0,
            {{MAX_DIM{Q_MAX}}, {(MAX_DIM*MAX_DIM){Q_MIN}}}, 1'b1, {MAX_DIM{Q_MIN}}, 1'b1));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b0, 2'd3, 1'b0, rand_point(), 1'b0, '0, 1'b0));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b1, 2'd3, 1'b0, rand_point(), 1'b0, '0, 1'b0));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b1, 2'd3, 1'b0,
            {32'h0, 32'h0, 32'h0002_0000, 192'h0, 32'h0, ONE_Q, 32'h0},
            1'b1, {32'h0, 32'h0002_0000, 32'h0}, 1'b0));
        dir_tab.push_back(mk_row(KIND_SCALAR, 1'b0, 2'd3, 1'b0, rand_point(), 1'b0, '0, 1'b0));
        // transpose has no effect on scalar and diagonal
        dir_tab.push_back(mk_row(KIND_SCALAR, 1'b1, 2'd3, 1'b0, rand_point(), 1'b0, '0, 1'b0));
        dir_tab.push_back(mk_row(KIND_DIAG, 1'b0, 2'd3, 1'b0, rand_point(), 1'b0, '0, 1'b0));
        dir_tab.push_back(mk_row(KIND_DIAG, 1'b1, 2'd2, 1'b0, rand_point(), 1'b0, '0, 1'b0));
        dir_tab.push_back(mk_row(KIND_DIAG, 1'b0, 2'd3, 1'b0, {IN_FIELDS{Q_MAX}},
            1'b1, {MAX_DIM{Q_MAX}}, 1'b1));
        // spare kind code behaves as a full matrix
        dir_tab.push_back(mk_row(KIND_UNUSED, 1'b0, 2'd3, 1'b0, rand_point(), 1'b0, '0, 1'b0));
        dir_tab.push_back(mk_row(KIND_UNUSED, 1'b1, 2'd3, 1'b0, rand_point(), 1'b0, '0, 1'b0));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b0, 2'd0, 1'b0, {IN_FIELDS{Q_MAX}},
            1'b1, '0, 1'b0));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b0, 2'd1, 1'b0, {IN_FIELDS{Q_MAX}},
            1'b1, {64'h0, Q_MAX}, 1'b1));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b0, 2'd2, 1'b0, rand_point(), 1'b0, '0, 1'b0));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b1, 2'd2, 1'b0, rand_point(), 1'b0, '0, 1'b0));
        // truncation rounds toward minus infinity
        dir_tab.push_back(mk_row(KIND_SCALAR, 1'b0, 2'd1, 1'b0,
            {32'h0, 32'h0, 32'h1, 256'h0, 32'hFFFF_FFFF}, 1'b1, {64'h0, 32'hFFFF_FFFF}, 1'b0));
        // write to the spare register index is dropped
        dir_tab.push_back(mk_row(KIND_FULL, 1'b0, 2'd3, 1'b1, rand_point(), 1'b0, '0, 1'b0));
        dir_tab.push_back(mk_row(KIND_FULL, 1'b0, 2'd3, 1'b0, rand_point(), 1'b0, '0, 1'b0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind != sh_kind || dir_tab[i].trn != sh_trn ||
                dir_tab[i].dim != sh_dim || dir_tab[i].junk_wr)
                set_config(dir_tab[i].kind, dir_tab[i].trn, dir_tab[i].dim,
                           dir_tab[i].junk_wr);
            send_item(dir_tab[i].pt, dir_tab[i].typed, dir_tab[i].prod);
        end

        for (ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                tx_idle_pct = 87;
                rx_idle_pct = 10;
            end
            else if (ph == 2)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            sent = 0;
            while (sent < RAND_ITEMS / 3)
            begin
                set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           ($urandom_range(0, 5) == 0) ? '0 : DIM_W'($urandom_range(1, 3)),
                           $urandom_range(0, 7) == 0);
                n_blk = $urandom_range(10, 100);
                repeat (n_blk)
                    send_item(rand_point(), 1'b0, '0);
                sent += n_blk;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/pwmv_pkg.sv
hdl/pwmv_lane.sv
hdl/pwmv_merge.sv
hdl/pointwise_small_matvec.sv
tb/sv/tb_top.sv
